/* rtl/prf_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// prf_pkg: shared types for the packet replay filter
// Command word passed from the front classifier to the back executor.
// ============================================================================
package prf_pkg;

    // fixed field widths of one input word
    localparam int PEER_W = 4;
    localparam int SEQ_W  = 64;
    localparam int ID_W   = 64;

    // depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // request kinds
    typedef enum logic {
        OP_CHECK = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    // classified request
    typedef struct packed {
        op_t               op;
        logic [PEER_W-1:0] peer;
        logic              peer_in_range;
        logic              peer_ok;
        logic              boot;
        logic              id_zero;
        logic              seq_zero;
        logic [SEQ_W-1:0]  seq;
        logic [ID_W-1:0]   id;
    } cmd_t;

endpackage

/* rtl/prf_front.sv */
`timescale 1ns / 1ps
// ============================================================================
// prf_front: input stage of the packet replay filter
// Accepts input words, decodes and classifies them into command words.
// ============================================================================
module prf_front
    import prf_pkg::*;
#(
    parameter int PEER_COUNT = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // peer_index[3:0], has_peer[4], is_bootstrap[5], sequence_req[69:6],
    // pkt_id[133:70], zero fill[135:134]
    input  logic [135:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         push_valid,
    input  logic         push_ready,
    output cmd_t         push_data
);

    logic front_vld_reg;
    logic front_vld_next;
    cmd_t front_cmd_reg;
    cmd_t cmd_dec;
    logic accept;

    // field decode and classification
    always_comb
    begin
        cmd_dec.op            = s_axis_tuser[0] ? OP_CLEAR : OP_CHECK;
        cmd_dec.peer          = s_axis_tdata[3:0];
        cmd_dec.peer_in_range = (32'(s_axis_tdata[3:0]) < PEER_COUNT);
        cmd_dec.peer_ok       = s_axis_tdata[4] && (32'(s_axis_tdata[3:0]) < PEER_COUNT);
        cmd_dec.boot          = s_axis_tdata[5];
        cmd_dec.seq           = s_axis_tdata[69:6];
        cmd_dec.id            = s_axis_tdata[133:70];
        cmd_dec.seq_zero      = (s_axis_tdata[69:6] == '0);
        cmd_dec.id_zero       = (s_axis_tdata[133:70] == '0);
    end

    // one-word holding stage toward the queue
    assign s_axis_tready = !front_vld_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_valid    = front_vld_reg;
    assign push_data     = front_cmd_reg;

    always_comb
    begin
        front_vld_next = front_vld_reg;
        if (accept)
        begin
            front_vld_next = 1'b1;
        end
        else if (push_ready)
        begin
            front_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
        end
        else
        begin
            front_vld_reg <= front_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_cmd_reg <= cmd_dec;
        end
    end

endmodule

/* rtl/prf_queue.sv */
`timescale 1ns / 1ps
// ============================================================================
// prf_queue: command queue between front and back
// Small circular buffer so either side can stall on its own.
// ============================================================================
module prf_queue
    import prf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = q_mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/prf_back.sv */
`timescale 1ns / 1ps
// ============================================================================
// prf_back: executor of the packet replay filter
// Scans the recent-id ring, updates it and the per-peer sliding window,
// and holds the verdict word in an output register.
// ============================================================================
module prf_back
    import prf_pkg::*;
#(
    parameter int WINDOW_BITS = 64,
    parameter int RING_DEPTH  = 64,
    parameter int PEER_COUNT  = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  cmd_t       pop_data,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    // replayed[0], zero fill[7:1]
    output logic [7:0] m_axis_tdata
);

    localparam int PEER_DEPTH = (PEER_COUNT < (1 << PEER_W)) ? PEER_COUNT : (1 << PEER_W);
    localparam int PIDX_W     = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;
    localparam int RIDX_W     = $clog2(RING_DEPTH);
    localparam int WIDX_W     = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WIN_CMP,
        S_WIN_UPD,
        S_RESP
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic                   issue_reg, issue_next;
    logic [RIDX_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                   rd_vld_reg;
    logic [RIDX_W-1:0]      rd_idx_reg;
    logic [ID_W-1:0]        rd_data_reg;
    logic                   hit_reg, hit_next;
    logic [RIDX_W-1:0]      pos_reg, pos_next;
    logic [RIDX_W:0]        fill_reg, fill_next;
    logic [SEQ_W-1:0]       hi_reg, hi_next;
    logic [WINDOW_BITS-1:0] win_reg, win_next;
    logic [SEQ_W-1:0]       dist_reg, dist_next;
    logic                   gt_reg, gt_next;
    logic                   res_reg, res_next;
    logic                   out_vld_reg, out_vld_next;
    logic                   out_res_reg, out_res_next;

    logic [ID_W-1:0]        ring_mem [RING_DEPTH];
    logic [SEQ_W-1:0]       peer_hi_reg [PEER_DEPTH];
    logic [WINDOW_BITS-1:0] peer_win_reg [PEER_DEPTH];

    logic                   ring_wr_en;
    logic                   peer_clr_en;
    logic                   peer_wr_en;
    logic [SEQ_W-1:0]       peer_hi_wr;
    logic [WINDOW_BITS-1:0] peer_win_wr;
    logic [PIDX_W-1:0]      clr_idx;
    logic [PIDX_W-1:0]      cmd_idx;
    logic                   rd_match;
    logic [WIDX_W-1:0]      widx;
    logic                   dist_lt;
    logic                   win_bit;
    logic [WINDOW_BITS-1:0] win_adv;

    assign clr_idx   = pop_data.peer[PIDX_W-1:0];
    assign cmd_idx   = cmd_reg.peer[PIDX_W-1:0];
    assign pop_ready = (state_reg == S_IDLE);

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {7'b0, out_res_reg};

    // ring compare, only entries already written take part
    assign rd_match = rd_vld_reg && ({1'b0, rd_idx_reg} < fill_reg)
                      && (rd_data_reg == cmd_reg.id);

    // window arithmetic on the registered distance
    assign widx    = dist_reg[WIDX_W-1:0];
    assign dist_lt = (dist_reg < SEQ_W'(WINDOW_BITS));
    assign win_bit = dist_lt && win_reg[widx];
    assign win_adv = dist_lt ? ((win_reg << widx) | WINDOW_BITS'(1)) : WINDOW_BITS'(1);

    // sequencer next-state logic
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        issue_next     = issue_reg;
        scan_addr_next = scan_addr_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        hi_next        = hi_reg;
        win_next       = win_reg;
        dist_next      = dist_reg;
        gt_next        = gt_reg;
        res_next       = res_reg;
        out_res_next   = out_res_reg;
        out_vld_next   = out_vld_reg && !m_axis_tready;
        ring_wr_en     = 1'b0;
        peer_clr_en    = 1'b0;
        peer_wr_en     = 1'b0;
        peer_hi_wr     = hi_reg;
        peer_win_wr    = win_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next = pop_data;
                    if (pop_data.op == OP_CLEAR)
                    begin
                        peer_clr_en = pop_data.peer_in_range;
                        res_next    = 1'b0;
                        state_next  = S_RESP;
                    end
                    else if (pop_data.id_zero)
                    begin
                        res_next   = 1'b1;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        issue_next     = 1'b1;
                        scan_addr_next = '0;
                        hit_next       = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue_reg)
                begin
                    if (scan_addr_reg == RIDX_W'(RING_DEPTH - 1))
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + 1'b1;
                    end
                end
                if (rd_match)
                begin
                    hit_next = 1'b1;
                end
                if (rd_vld_reg && (rd_idx_reg == RIDX_W'(RING_DEPTH - 1)))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (hit_reg)
                begin
                    res_next   = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    ring_wr_en = 1'b1;
                    pos_next   = (pos_reg == RIDX_W'(RING_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
                    if (fill_reg != (RIDX_W+1)'(RING_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (cmd_reg.peer_ok)
                    begin
                        hi_next    = peer_hi_reg[cmd_idx];
                        win_next   = peer_win_reg[cmd_idx];
                        state_next = S_WIN_CMP;
                    end
                    else
                    begin
                        res_next   = 1'b0;
                        state_next = S_RESP;
                    end
                end
            end
            S_WIN_CMP:
            begin
                gt_next    = (cmd_reg.seq > hi_reg);
                dist_next  = (cmd_reg.seq > hi_reg) ? (cmd_reg.seq - hi_reg)
                                                    : (hi_reg - cmd_reg.seq);
                state_next = S_WIN_UPD;
            end
            S_WIN_UPD:
            begin
                state_next = S_RESP;
                res_next   = 1'b0;
                if (cmd_reg.boot)
                begin
                    // bootstrap only moves the window forward
                    if (!cmd_reg.seq_zero && gt_reg)
                    begin
                        peer_wr_en  = 1'b1;
                        peer_hi_wr  = cmd_reg.seq;
                        peer_win_wr = win_adv;
                    end
                end
                else if (cmd_reg.seq_zero)
                begin
                    res_next = 1'b1;
                end
                else if (gt_reg)
                begin
                    peer_wr_en  = 1'b1;
                    peer_hi_wr  = cmd_reg.seq;
                    peer_win_wr = win_adv;
                end
                else if (!dist_lt || win_bit)
                begin
                    res_next = 1'b1;
                end
                else
                begin
                    peer_wr_en  = 1'b1;
                    peer_hi_wr  = hi_reg;
                    peer_win_wr = win_reg | (WINDOW_BITS'(1) << widx);
                end
            end
            S_RESP:
            begin
                if (!out_vld_reg || m_axis_tready)
                begin
                    out_vld_next = 1'b1;
                    out_res_next = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            issue_reg     <= 1'b0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
            hit_reg       <= 1'b0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            hi_reg        <= '0;
            win_reg       <= '0;
            dist_reg      <= '0;
            gt_reg        <= 1'b0;
            res_reg       <= 1'b0;
            out_vld_reg   <= 1'b0;
            out_res_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            issue_reg     <= issue_next;
            scan_addr_reg <= scan_addr_next;
            rd_vld_reg    <= (state_reg == S_SCAN) && issue_reg;
            rd_idx_reg    <= scan_addr_reg;
            hit_reg       <= hit_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            hi_reg        <= hi_next;
            win_reg       <= win_next;
            dist_reg      <= dist_next;
            gt_reg        <= gt_next;
            res_reg       <= res_next;
            out_vld_reg   <= out_vld_next;
            out_res_reg   <= out_res_next;
        end
    end

    // recent-id ring memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ring_wr_en)
        begin
            ring_mem[pos_reg] <= cmd_reg.id;
        end
        rd_data_reg <= ring_mem[scan_addr_reg];
    end

    // per-peer highest sequence and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PEER_DEPTH; i++)
            begin
                peer_hi_reg[i]  <= '0;
                peer_win_reg[i] <= '0;
            end
        end
        else if (peer_clr_en)
        begin
            peer_hi_reg[clr_idx]  <= '0;
            peer_win_reg[clr_idx] <= '0;
        end
        else if (peer_wr_en)
        begin
            peer_hi_reg[cmd_idx]  <= peer_hi_wr;
            peer_win_reg[cmd_idx] <= peer_win_wr;
        end
    end

    // a zero id never enters the ring
    a_ring_wr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ring_wr_en |-> (cmd_reg.id != '0))
        else $error("ring written with zero id");

    // fill count and ring position stay inside the ring
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= (RIDX_W+1)'(RING_DEPTH)) && (32'(pos_reg) < RING_DEPTH))
        else $error("ring fill or position out of range");

    // the scan has issued every address before the verdict is taken
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (!issue_reg && !rd_vld_reg))
        else $error("ring scan not finished at decision");

    // a peer entry is updated only for an in-range known peer after a ring pass
    a_peer_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
        peer_wr_en |-> (cmd_reg.peer_ok && !hit_reg && (cmd_reg.op == OP_CHECK)))
        else $error("peer window written for a rejected or peerless word");

    // a verdict enters the output register only from the response state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_vld_reg && out_vld_next) |-> (state_reg == S_RESP))
        else $error("output loaded outside response state");

endmodule

/* rtl/packet_replay_filter_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// packet_replay_filter_top: anti-replay filter with recent-id ring and
// per-peer sliding window
// A check word's verdict follows a scan of the whole recent-id ring, one entry a
// cycle, then the window compare and update states; a ring hit or a word with
// no peer skips the window states, and clear and zero-id words skip the scan.
// The executor takes a new word only once the last verdict is in the output
// register, and output stalls hold it back.
// Reset: asynchronous active low, empties queue and output, zeroes peer windows,
// ring position and ring fill count; ring contents are ignored until written.
// ============================================================================
module packet_replay_filter_top
    import prf_pkg::*;
#(
    parameter int WINDOW_BITS = 64,
    parameter int RING_DEPTH  = 64,
    parameter int PEER_COUNT  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // peer_index[3:0], has_peer[4], is_bootstrap[5], sequence_req[69:6],
    // pkt_id[133:70], zero fill[135:134]
    input  logic [135:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // replayed[0], zero fill[7:1]
    output logic [7:0]   m_axis_tdata
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_data;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_data;

    // input decode and classification
    prf_front #(
        .PEER_COUNT (PEER_COUNT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (fq_valid),
        .push_ready    (fq_ready),
        .push_data     (fq_data)
    );

    // command queue
    prf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // ring scan, window update and verdict
    prf_back #(
        .WINDOW_BITS (WINDOW_BITS),
        .RING_DEPTH  (RING_DEPTH),
        .PEER_COUNT  (PEER_COUNT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (qb_valid),
        .pop_ready     (qb_ready),
        .pop_data      (qb_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* bench/replay_verdict_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// replay_verdict_checker: verdict predictor and comparator for the filter
// Watches both stream channels of the replay filter. Every accepted input
// word is run through a local copy of the recent-id ring and the per-peer
// sliding windows. The expected verdict is queued, and each output word is
// compared with the oldest queued verdict.
// ============================================================================
module replay_verdict_checker
    import prf_pkg::*;
#(
    parameter int WINDOW_BITS = 64,
    parameter int RING_DEPTH  = 64,
    parameter int PEER_COUNT  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    // peer_index[3:0], has_peer[4], is_bootstrap[5], sequence_req[69:6],
    // pkt_id[133:70], zero fill[135:134]
    input  logic [135:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // replayed[0], zero fill[7:1]
    input  logic [7:0]   m_axis_tdata,
    output int           mismatches,
    output int           pending
);

    localparam logic [63:0] WIN_MASK = {64{1'b1}} >> (64 - WINDOW_BITS);

    // local copy of the filter state
    logic [63:0] highest_seq [PEER_COUNT];
    logic [63:0] seen_bits   [PEER_COUNT];
    logic [63:0] recent_ids  [RING_DEPTH];
    int          ring_pos;

    // verdicts waiting for their output word
    logic        verdict_q [$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // move a peer window forward to a newer sequence
    function automatic void slide_window(int p, logic [63:0] seq);
        logic [63:0] gap;
        gap = seq - highest_seq[p];
        if (gap >= WINDOW_BITS)
            seen_bits[p] = 64'd1;
        else
            seen_bits[p] = ((seen_bits[p] << gap) | 64'd1) & WIN_MASK;
        highest_seq[p] = seq;
    endfunction

    // verdict of one word, updating ring and windows on the way
    function automatic logic predict_verdict(op_t op, logic [3:0] peer, logic has_peer,
                                             logic boot, logic [63:0] seq, logic [63:0] id);
        logic        hit;
        logic [63:0] gap;
        int          p;
        p = int'(peer);
        if (op == OP_CLEAR)
        begin
            if (p < PEER_COUNT)
            begin
                highest_seq[p] = '0;
                seen_bits[p]   = '0;
            end
            return 1'b0;
        end
        // global ring check; zero entries cannot match a nonzero id
        hit = (id == '0);
        for (int i = 0; i < RING_DEPTH; i++)
            if (recent_ids[i] == id)
                hit = 1'b1;
        if (hit)
            return 1'b1;
        recent_ids[ring_pos] = id;
        ring_pos = (ring_pos + 1) % RING_DEPTH;
        if (!has_peer || p >= PEER_COUNT)
            return 1'b0;
        // bootstrap words only push the window forward
        if (boot)
        begin
            if (seq != '0 && seq > highest_seq[p])
                slide_window(p, seq);
            return 1'b0;
        end
        if (seq == '0)
            return 1'b1;
        if (seq > highest_seq[p])
        begin
            slide_window(p, seq);
            return 1'b0;
        end
        gap = highest_seq[p] - seq;
        if (gap >= WINDOW_BITS)
            return 1'b1;
        if ((seen_bits[p] & (64'd1 << gap)) != '0)
            return 1'b1;
        seen_bits[p] = seen_bits[p] | (64'd1 << gap);
        return 1'b0;
    endfunction

    // predict on input words, compare on output words
    always @(posedge clk or negedge rst_n)
    begin
        logic expected;
        if (!rst_n)
        begin
            for (int i = 0; i < PEER_COUNT; i++)
            begin
                highest_seq[i] = '0;
                seen_bits[i]   = '0;
            end
            for (int i = 0; i < RING_DEPTH; i++)
                recent_ids[i] = '0;
            ring_pos   = 0;
            mismatches = 0;
            verdict_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_q.push_back(predict_verdict(op_t'(s_axis_tuser[0]),
                                                    s_axis_tdata[3:0], s_axis_tdata[4],
                                                    s_axis_tdata[5], s_axis_tdata[69:6],
                                                    s_axis_tdata[133:70]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("verdict word with no word waiting for it");
                end
                else
                begin
                    expected = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== expected)
                        report_mismatch($sformatf("replayed is %b, expected %b",
                                                  m_axis_tdata[0], expected));
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

/* bench/packet_replay_filter_top_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// packet_replay_filter_top_tb: stimulus and verdict for the replay filter
// Drives directed words through the ring and window corner cases, then
// random per-peer sequence streams with fresh, repeated and zero ids, with
// random idle bursts on both channels. The checker predicts and compares.
// ============================================================================
module packet_replay_filter_top_tb;
    import prf_pkg::*;

    localparam int  RANDOM_WORDS = 750;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  TAIL_CYCLES  = 120;
    localparam int  ID_HISTORY   = 80;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;

    int           mismatches;
    int           pending;
    int           cycle_count = 0;
    logic         idle_on;

    // tb-side guess of each peer's newest sequence and of recently used ids
    logic [63:0]  next_seq [16];
    logic [63:0]  id_history [$];

    packet_replay_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    replay_verdict_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // output side stalls in random bursts
    initial
    begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end
            else
            begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // present one word and hold it until accepted
    task automatic send_word(op_t op, logic [3:0] peer, logic has_peer, logic boot,
                             logic [63:0] seq, logic [63:0] id);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tdata  = {2'b00, id, seq, boot, has_peer, peer};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        id_history.push_back(id);
        if (id_history.size() > ID_HISTORY)
            void'(id_history.pop_front());
    endtask

    // hold off until every queued verdict has come out
    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // random word, mostly a check built around a peer's current sequence
    task automatic send_random_word();
        logic [3:0]  peer;
        logic        has_peer;
        logic        boot;
        logic [63:0] seq;
        logic [63:0] id;
        int          pick;
        peer     = 4'($urandom_range(0, 15));
        has_peer = ($urandom_range(0, 99) < 85);
        boot     = ($urandom_range(0, 99) < 15);
        // clear a peer now and then
        if ($urandom_range(0, 99) < 4)
        begin
            next_seq[peer] = '0;
            send_word(OP_CLEAR, peer, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      {$urandom, $urandom}, {$urandom, $urandom});
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70)
            seq = next_seq[peer] + 64'($urandom_range(1, 8));
        else if (pick < 85)
            seq = next_seq[peer] - 64'($urandom_range(0, 70));
        else if (pick < 90)
            seq = next_seq[peer] + 64'($urandom_range(64, 1000));
        else if (pick < 95)
            seq = '0;
        else
            seq = {$urandom, $urandom};
        if (seq > next_seq[peer])
            next_seq[peer] = seq;
        pick = $urandom_range(0, 99);
        if (pick < 88 || id_history.size() == 0)
            id = {$urandom, $urandom};
        else if (pick < 98)
            id = id_history[$urandom_range(0, id_history.size() - 1)];
        else
            id = '0;
        send_word(OP_CHECK, peer, has_peer, boot, seq, id);
    endtask

    // main stimulus
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        idle_on       = 1'b1;
        for (int i = 0; i < 16; i++)
            next_seq[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ring and window corners on peer 0 and peer 15
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd1, 64'd0);        // id zero
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd1, 64'd1);
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd2, 64'd1);        // id in ring
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd2, ALL_ONES);
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd2, 64'd5);        // already seen
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd0, 64'd6);        // sequence zero
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b1, 64'd0, 64'd7);        // bootstrap, seq zero
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd100, 64'd8);      // large jump
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd36, 64'd9);       // just too old
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd37, 64'd10);      // oldest in window
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd37, 64'd11);
        send_word(OP_CHECK, 4'd0, 1'b0, 1'b0, 64'd37, 64'd12);      // no peer
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b1, 64'd200, 64'd13);     // bootstrap advance
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b1, 64'd150, 64'd14);     // bootstrap behind
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd200, 64'd15);
        send_word(OP_CLEAR, 4'd0, 1'b1, 1'b0, 64'd0, 64'd0);
        send_word(OP_CHECK, 4'd0, 1'b1, 1'b0, 64'd1, 64'd16);
        send_word(OP_CHECK, 4'd15, 1'b1, 1'b0, ALL_ONES, 64'd17);
        send_word(OP_CHECK, 4'd15, 1'b1, 1'b0, ALL_ONES - 64'd1, 64'd18);
        send_word(OP_CHECK, 4'd15, 1'b1, 1'b0, ALL_ONES, 64'd19);
        send_word(OP_CLEAR, 4'd15, 1'b0, 1'b1, ALL_ONES, ALL_ONES);
        send_word(OP_CHECK, 4'd15, 1'b1, 1'b0, 64'd1, 64'd20);
        send_word(OP_CHECK, 4'd15, 1'b1, 1'b1, 64'd5, 64'd0);       // bootstrap, id zero

        // let the filter go quiet before the random part
        wait_drain();

        // random part; the last stretch runs without idling
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n >= RANDOM_WORDS - 100)
                idle_on = 1'b0;
            else if (n % 50 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (n == RANDOM_WORDS / 2)
                wait_drain();
            send_random_word();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/prf_pkg.sv
rtl/prf_front.sv
rtl/prf_queue.sv
rtl/prf_back.sv
rtl/packet_replay_filter_top.sv
bench/replay_verdict_checker.sv
bench/packet_replay_filter_top_tb.sv
